FILE: hdl/cpli_pkg.sv
package cpli_pkg;

   // item kinds carried on req_tuser
   typedef enum logic [2:0] {
      KIND_CURRENT  = 3'd0,
      KIND_FRACTION = 3'd1,
      KIND_INCREASE = 3'd2,
      KIND_DECREASE = 3'd3,
      KIND_TICK     = 3'd4,
      KIND_REINIT   = 3'd5
   } kind_type;

   localparam int ActWidth = 40;

   // configuration register set
   typedef struct packed {
      logic signed [31:0] basal;
      logic        [15:0] decay;
      logic signed [31:0] gain;
      logic signed [31:0] ceiling;
      logic signed [31:0] floor_lvl;
   } cfg_type;

   // partial products of drive_gain * activation, handed to the update stage
   typedef struct packed {
      logic               reinit;
      logic signed [56:0] p_lo;   // gain * activation[23:0]
      logic signed [47:0] p_hi;   // gain * activation[39:24]
   } tick_type;

endpackage

FILE: hdl/cpli_accum.sv
module cpli_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [2:0]           kind,
   input  logic signed [31:0]   amount,
   input  logic [16:0]          fraction,
   input  logic signed [31:0]   gain,
   output cpli_pkg::tick_type   tick
);
   import cpli_pkg::*;

   localparam logic signed [ActWidth-1:0] ActMax = {1'b0, {(ActWidth-1){1'b1}}};
   localparam logic signed [ActWidth-1:0] ActMin = {1'b1, {(ActWidth-1){1'b0}}};

   logic signed [ActWidth-1:0] act_ff, act_in;
   logic signed [49:0]         frac_prod;
   logic signed [32:0]         amount_mag;
   logic signed [ActWidth:0]   addend;
   logic signed [ActWidth:0]   act_sum;
   logic signed [ActWidth-1:0] act_sat;

   // floor of amount * fraction / 2^16 falls out of the arithmetic select
   assign frac_prod  = amount * $signed({1'b0, fraction});
   assign amount_mag = amount[31] ? -33'(amount) : 33'(amount);

   always_comb begin
      unique case (kind)
         KIND_CURRENT:  addend = 41'(amount);
         KIND_FRACTION: addend = 41'($signed(frac_prod[49:16]));
         KIND_INCREASE: addend = 41'(amount_mag);
         KIND_DECREASE: addend = -41'(amount_mag);
         default:       addend = '0;
      endcase
   end

   assign act_sum = 41'(act_ff) + addend;

   always_comb begin
      if (act_sum[ActWidth] != act_sum[ActWidth-1]) begin
         act_sat = act_sum[ActWidth] ? ActMin : ActMax;
      end else begin
         act_sat = act_sum[ActWidth-1:0];
      end
   end

   always_comb begin
      act_in = act_ff;
      if (go) begin
         unique case (kind)
            KIND_CURRENT, KIND_FRACTION,
            KIND_INCREASE, KIND_DECREASE: act_in = act_sat;
            KIND_TICK, KIND_REINIT:       act_in = '0;
            default:                      act_in = act_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
      end else begin
         act_ff <= act_in;
      end
   end

   // split multiply keeps each product within 32 x 25 bits
   assign tick.reinit = (kind == KIND_REINIT);
   assign tick.p_lo   = gain * $signed({1'b0, act_ff[23:0]});
   assign tick.p_hi   = gain * $signed(act_ff[ActWidth-1:24]);

endmodule

FILE: hdl/cpli_update.sv
module cpli_update (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  cpli_pkg::tick_type   tick,
   input  cpli_pkg::cfg_type    cfg,
   output logic signed [31:0]   conc
);
   import cpli_pkg::*;

   logic signed [31:0] dev_ff, dev_in;
   logic signed [71:0] drive_full;
   logic signed [48:0] decay_prod;
   logic signed [57:0] conc_sum;
   logic signed [31:0] conc_clamp;
   logic signed [32:0] dev_diff;
   logic signed [31:0] dev_sat;

   assign drive_full = (72'(tick.p_hi) <<< 24) + 72'(tick.p_lo);
   assign decay_prod = dev_ff * $signed({1'b0, cfg.decay});

   assign conc_sum = 58'(cfg.basal)
                   + 58'($signed(decay_prod[48:16]))
                   + 58'($signed(drive_full[71:16]));

   // ceiling test wins when floor sits above ceiling
   always_comb begin
      priority if (conc_sum > 58'(cfg.ceiling)) begin
         conc_clamp = cfg.ceiling;
      end else if (conc_sum < 58'(cfg.floor_lvl)) begin
         conc_clamp = cfg.floor_lvl;
      end else begin
         conc_clamp = conc_sum[31:0];
      end
   end

   assign dev_diff = 33'(conc_clamp) - 33'(cfg.basal);

   always_comb begin
      if (dev_diff[32] != dev_diff[31]) begin
         dev_sat = dev_diff[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end else begin
         dev_sat = dev_diff[31:0];
      end
   end

   assign conc = tick.reinit ? cfg.basal : conc_clamp;

   always_comb begin
      dev_in = dev_ff;
      if (go) begin
         dev_in = tick.reinit ? '0 : dev_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff <= '0;
      end else begin
         dev_ff <= dev_in;
      end
   end

endmodule

FILE: hdl/calcium_pool_leaky_integrator.sv
// channel   direction  handshake                 payload
// req       in         req_tvalid / req_tready   tuser kind, tdata amount + fraction
// rsp       out        rsp_tvalid / rsp_tready   tdata conc
// csr       in         csr_valid / csr_ready     csr_index, csr_data
//
// one item per cycle sustained while rsp_tready stays high; a tick or reinit passes the input register,
// product register and result register in turn before rsp_tvalid rises
// current, fraction, increase and decrease events finish in the input stage and give no result
// reset is synchronous: clears activation, deviation, pipeline valids, registers
// to their defaults; a stalled rsp backs up the result stages, events keep draining
// until a tick or reinit has to wait in the input stage
module calcium_pool_leaky_integrator (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,    // [2:0] kind
   input  logic [55:0]  req_tdata,    // [31:0] amount, [48:32] fraction, [55:49] zero

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,    // [31:0] conc

   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import cpli_pkg::*;

   localparam logic [2:0] CSR_BASAL   = 3'd0;
   localparam logic [2:0] CSR_DECAY   = 3'd1;
   localparam logic [2:0] CSR_GAIN    = 3'd2;
   localparam logic [2:0] CSR_CEILING = 3'd3;
   localparam logic [2:0] CSR_FLOOR   = 3'd4;

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // stage 1: input register
   logic               s1_valid_ff, s1_valid_in;
   logic [2:0]         s1_kind_ff, s1_kind_in;
   logic signed [31:0] s1_amount_ff, s1_amount_in;
   logic [16:0]        s1_fraction_ff, s1_fraction_in;

   // stage 2: product register (ticks and reinits only)
   logic               s2_valid_ff, s2_valid_in;
   tick_type           s2_tick_ff, s2_tick_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   tick_type           s1_tick;
   logic signed [31:0] s2_conc;
   logic               out_free, go2, s2_free, s1_result, go1, req_take;

   // handshake chain: each stage moves when the one after it has room; events that give no result leave stage 1 anyway
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign go2       = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || go2;
   assign s1_result = (s1_kind_ff == KIND_TICK) || (s1_kind_ff == KIND_REINIT);
   assign go1       = s1_valid_ff && (!s1_result || s2_free);
   assign req_tready = !s1_valid_ff || go1;
   assign req_take  = req_tvalid && req_tready;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASAL:   cfg_in.basal     = csr_data;
            CSR_DECAY:   cfg_in.decay     = csr_data[15:0];
            CSR_GAIN:    cfg_in.gain      = csr_data;
            CSR_CEILING: cfg_in.ceiling   = csr_data;
            CSR_FLOOR:   cfg_in.floor_lvl = csr_data;
            default:     cfg_in = cfg_ff;   // unknown index is dropped
         endcase
      end
   end

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_kind_in     = s1_kind_ff;
      s1_amount_in   = s1_amount_ff;
      s1_fraction_in = s1_fraction_ff;
      if (req_take) begin
         s1_valid_in    = 1'b1;
         s1_kind_in     = req_tuser;
         s1_amount_in   = req_tdata[31:0];
         s1_fraction_in = req_tdata[48:32];
      end else if (go1) begin
         s1_valid_in    = 1'b0;
      end
   end

   // activation update and split drive product
   cpli_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .go       (go1),
      .kind     (s1_kind_ff),
      .amount   (s1_amount_ff),
      .fraction (s1_fraction_ff),
      .gain     (cfg_ff.gain),
      .tick     (s1_tick)
   );

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_tick_in  = s2_tick_ff;
      if (go1 && s1_result) begin
         s2_valid_in = 1'b1;
         s2_tick_in  = s1_tick;
      end else if (go2) begin
         s2_valid_in = 1'b0;
      end
   end

   // decay, sum, clamp and deviation store
   cpli_update u_update (
      .clock (clock),
      .reset (reset),
      .go    (go2),
      .tick  (s2_tick_ff),
      .cfg   (cfg_ff),
      .conc  (s2_conc)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (go2) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = s2_conc;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.basal     <= '0;
         cfg_ff.decay     <= 16'hFFFF;
         cfg_ff.gain      <= '0;
         cfg_ff.ceiling   <= {1'b0, {31{1'b1}}};
         cfg_ff.floor_lvl <= {1'b1, 31'd0};
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cfg_ff           <= cfg_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      s1_kind_ff     <= s1_kind_in;
      s1_amount_ff   <= s1_amount_in;
      s1_fraction_ff <= s1_fraction_in;
      s2_tick_ff     <= s2_tick_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
